// ===== rtl/core/lrst_pkg.sv =====
package lrst_pkg;

    // tree shape
    localparam int LOG_LEAVES = 10;
    localparam int LEAVES     = 1 << LOG_LEAVES;
    localparam int NODES      = 2 * LEAVES;
    localparam int IDX_W      = LOG_LEAVES;
    localparam int NODE_W     = LOG_LEAVES + 1;
    localparam int LVL_W      = $clog2(LOG_LEAVES + 1);

    // payload widths
    localparam int SUM_W      = 64;
    localparam int VAL_W      = 32;
    localparam int ENTRY_W    = 2 * SUM_W;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 64;

    // operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // candidate slots per level
    localparam int SLOT_W     = 2;
    localparam logic [SLOT_W-1:0] SLOT_LAST = 2'd3;

    // one node that the walk may touch at a given level
    typedef struct packed {
        logic              valid;
        logic              full;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] ovl;
        logic [NODE_W-1:0] len;
    } node_info_t;

endpackage

// ===== rtl/core/lrst_mem.sv =====
module lrst_mem (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [lrst_pkg::NODE_W-1:0]   waddr,
    input  logic [lrst_pkg::ENTRY_W-1:0]  wdata,
    input  logic                          re,
    input  logic [lrst_pkg::NODE_W-1:0]   raddr,
    output logic [lrst_pkg::ENTRY_W-1:0]  rdata
);
    import lrst_pkg::*;

    logic [ENTRY_W-1:0] mem [NODES];
    logic [ENTRY_W-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lrst_node_sel.sv =====
module lrst_node_sel (
    input  logic [lrst_pkg::IDX_W-1:0]  range_lo,
    input  logic [lrst_pkg::IDX_W-1:0]  range_hi,
    input  logic [lrst_pkg::LVL_W-1:0]  level,
    input  logic [lrst_pkg::SLOT_W-1:0] slot,
    output lrst_pkg::node_info_t        info
);
    import lrst_pkg::*;

    logic [LVL_W-1:0]  cs;
    logic [LVL_W-1:0]  ps;
    logic [NODE_W-1:0] a_w;
    logic [NODE_W-1:0] b_w;
    logic [NODE_W-1:0] pa_off, pb_off, pa, pb;
    logic [NODE_W-1:0] plo_a, phi_a, plo_b, phi_b;
    logic              pa_part, pb_part;
    logic [NODE_W-1:0] par;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] node_off;
    logic [NODE_W-1:0] clo, chi, lo_m, hi_m;
    logic              hit;
    logic              cand_ok;

    assign cs  = LVL_W'(LOG_LEAVES) - level;
    assign ps  = cs + LVL_W'(1);
    assign a_w = NODE_W'(range_lo);
    assign b_w = NODE_W'(range_hi);

    // parents on the path to the low and high ends (level above)
    assign pa_off = a_w >> ps;
    assign pb_off = b_w >> ps;
    assign pa     = (NODE_W'(1) << (level - LVL_W'(1))) | pa_off;
    assign pb     = (NODE_W'(1) << (level - LVL_W'(1))) | pb_off;
    assign plo_a  = pa_off << ps;
    assign phi_a  = plo_a | ((NODE_W'(1) << ps) - NODE_W'(1));
    assign plo_b  = pb_off << ps;
    assign phi_b  = plo_b | ((NODE_W'(1) << ps) - NODE_W'(1));
    assign pa_part = !((plo_a >= a_w) && (phi_a <= b_w));
    assign pb_part = !((plo_b >= a_w) && (phi_b <= b_w));

    // candidate: a child of a partially covered parent, root at level zero
    always_comb begin
        par     = slot[1] ? pb : pa;
        cand_ok = slot[1] ? (pb_part && (pb != pa)) : pa_part;
        node    = {par[NODE_W-2:0], slot[0]};
        if (level == '0) begin
            node    = NODE_W'(1);
            cand_ok = (slot == '0);
        end
    end

    // span of the candidate and its overlap with the range
    assign node_off = node - (NODE_W'(1) << level);
    assign clo      = node_off << cs;
    assign chi      = clo | ((NODE_W'(1) << cs) - NODE_W'(1));
    assign lo_m     = (clo > a_w) ? clo : a_w;
    assign hi_m     = (chi < b_w) ? chi : b_w;
    assign hit      = (clo <= b_w) && (chi >= a_w);

    assign info.valid = cand_ok && hit;
    assign info.full  = (clo >= a_w) && (chi <= b_w);
    assign info.node  = node;
    assign info.ovl   = hit ? (hi_m - lo_m + NODE_W'(1)) : '0;
    assign info.len   = NODE_W'(1) << cs;

endmodule

// ===== rtl/core/lazy_range_add_range_sum_tree_core.sv =====
// Range-add / range-sum tree over 1024 signed 64-bit elements, all zero
// after reset. Each item either adds add_value to every element of
// [range_low, range_high] or queries the wrapped 64-bit sum of that range;
// only queries give a result item, and an empty range (low above high)
// changes nothing or sums to zero. Every node entry (sum and tag) lives in
// one single-port-read memory, so an item walks the eleven tree levels,
// checking one candidate at the root and four per level below it, and
// reads each node it touches, then writes it back (add) or adds it to the
// sum (query). The next item is taken only after the walk ends, and after
// a query only once the result side can take the sum, so a stall on the
// result side holds the input. After reset the block clears all 2048 node
// entries before it takes its first item.
module lazy_range_add_range_sum_tree_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // operation[0], range_low[10:1], range_high[20:11], add_value[52:21], zeros
    input  logic [lrst_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // range_sum[63:0]
    output logic [lrst_pkg::M_DATA_W-1:0]  m_tdata
);
    import lrst_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_READ  = 6'b001000,
        ST_WRITE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [NODE_W-1:0]   clr_reg, clr_next;
    logic                op_reg;
    logic [IDX_W-1:0]    lo_reg, hi_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [LVL_W-1:0]    level_reg, level_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [NODE_W-1:0]   node_reg;
    logic                full_reg;
    logic [NODE_W-1:0]   mulb_reg;
    logic [SUM_W-1:0]    prod_reg;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic                m_valid_reg, m_valid_next;
    logic [SUM_W-1:0]    m_data_reg;

    logic                in_op;
    logic [IDX_W-1:0]    in_lo, in_hi;
    logic signed [VAL_W-1:0] in_val;
    logic                s_fire;
    logic                out_free;
    logic                last_cand;

    node_info_t          info;
    logic                mem_we, mem_re;
    logic [NODE_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata, mem_rdata;
    logic [SUM_W-1:0]    rd_sum, rd_tag;
    logic [SUM_W-1:0]    val_ext;
    logic [SUM_W-1:0]    mul_a;

    // input unpacking
    assign in_op  = s_tdata[0];
    assign in_lo  = s_tdata[IDX_W:1];
    assign in_hi  = s_tdata[2*IDX_W:IDX_W+1];
    assign in_val = s_tdata[2*IDX_W+VAL_W:2*IDX_W+1];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    lrst_node_sel u_sel (
        .range_lo (lo_reg),
        .range_hi (hi_reg),
        .level    (level_reg),
        .slot     (slot_reg),
        .info     (info)
    );

    lrst_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (info.node),
        .rdata (mem_rdata)
    );

    // entry layout: tag in the upper half, subtree sum in the lower half
    assign rd_sum  = mem_rdata[SUM_W-1:0];
    assign rd_tag  = mem_rdata[ENTRY_W-1:SUM_W];
    assign val_ext = SUM_W'(val_reg);
    assign mul_a   = (op_reg == OP_QUERY) ? rd_tag : val_ext;

    assign last_cand = (level_reg == LVL_W'(LOG_LEAVES)) && (slot_reg == SLOT_LAST);

    // walk sequencer
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        level_next = level_reg;
        slot_next  = slot_reg;
        acc_next   = acc_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = node_reg;
        mem_wdata  = '0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + NODE_W'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    acc_next   = '0;
                    level_next = '0;
                    slot_next  = '0;
                    if (in_lo <= in_hi) begin
                        state_next = ST_SCAN;
                    end else if (in_op == OP_QUERY) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (info.valid) begin
                    mem_re     = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (op_reg == OP_ADD) begin
                    mem_we    = 1'b1;
                    mem_wdata = full_reg ? {rd_tag + val_ext, rd_sum}
                                         : {rd_tag, rd_sum + prod_reg};
                end else begin
                    acc_next = full_reg ? (acc_reg + rd_sum + prod_reg)
                                        : (acc_reg + prod_reg);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // step to the next candidate after a skip or a finished node
        if (((state_reg == ST_SCAN) && !info.valid) || (state_reg == ST_WRITE)) begin
            state_next = ST_SCAN;
            if ((level_reg == '0) || (slot_reg == SLOT_LAST)) begin
                level_next = level_reg + LVL_W'(1);
                slot_next  = '0;
            end else begin
                slot_next = slot_reg + SLOT_W'(1);
            end
            if (last_cand) begin
                state_next = (op_reg == OP_QUERY) ? ST_DONE : ST_IDLE;
            end
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if ((state_reg == ST_DONE) && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            level_reg   <= '0;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            level_reg   <= level_next;
            slot_reg    <= slot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (s_fire) begin
            op_reg  <= in_op;
            lo_reg  <= in_lo;
            hi_reg  <= in_hi;
            val_reg <= in_val;
        end
        if (state_reg == ST_SCAN) begin
            node_reg <= info.node;
            full_reg <= info.full;
            mulb_reg <= info.full ? info.len : info.ovl;
        end
        if (state_reg == ST_READ) begin
            prod_reg <= mul_a * SUM_W'(mulb_reg);
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_data_reg <= acc_reg;
        end
    end

endmodule

// ===== bench/lazy_range_add_range_sum_tree_core_test.sv =====
module lazy_range_add_range_sum_tree_core_test;
    import lrst_pkg::*;

    localparam int CYCLE_LIMIT = 900000;
    localparam int RANDOM_ITEMS = 680;
    localparam int CALM_ITEMS = 100;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LEAVES - 1);

    // Element-level mirror of the tree: every query answer is the wrapped sum
    // of the covered elements, so a flat array gives the same bits.
    class tree_scoreboard;
        logic [SUM_W-1:0] elem [LEAVES];
        logic [SUM_W-1:0] pending_sums [$];
        int errors;

        function new();
            foreach (elem[i]) elem[i] = '0;
            errors = 0;
        endfunction

        // note an accepted item: apply an add, or queue the expected sum
        function void note_item(logic op, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
                                logic [VAL_W-1:0] val);
            logic [SUM_W-1:0] ext;
            logic [SUM_W-1:0] acc;
            ext = {{(SUM_W-VAL_W){val[VAL_W-1]}}, val};
            acc = '0;
            for (int i = lo; i <= hi; i++) begin
                if (op == OP_ADD) elem[i] = elem[i] + ext;
                else acc = acc + elem[i];
            end
            if (op == OP_QUERY) pending_sums = {pending_sums, acc};
        endfunction

        function void check_sum(logic [SUM_W-1:0] actual);
            logic [SUM_W-1:0] want;
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected range_sum item: actual %h", $time, actual);
                errors++;
                return;
            end
            want = pending_sums.pop_front();
            if (want !== actual) begin
                $display("%0t: range_sum mismatch: expected %h actual %h",
                         $time, want, actual);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    tree_scoreboard sb = new();
    bit calm = 1'b0;
    int cycles = 0;

    lazy_range_add_range_sum_tree_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #6 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: accept and check, stalling in random bursts
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) sb.check_sum(m_tdata);
    end

    initial begin
        int n;
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 9);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // drive one item; valid stays high between back-to-back items
    task automatic send_item(logic op, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
                             logic [VAL_W-1:0] val);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_DATA_W-VAL_W-2*IDX_W-1){1'b0}}, val, hi, lo, op};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(op, lo, hi, val);
    endtask

    task automatic send_random();
        logic op;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [VAL_W-1:0] val;
        int w;
        op = 1'($urandom_range(0, 1));
        val = $urandom;
        lo = IDX_W'($urandom);
        case ($urandom_range(0, 5))
            0: hi = IDX_W'($urandom);
            1: begin
                w = $urandom_range(0, 7);
                hi = (int'(lo) + w > LEAVES - 1) ? LAST_IDX : IDX_W'(int'(lo) + w);
            end
            2: begin
                lo = IDX_W'($urandom_range(0, 15));
                hi = IDX_W'(LEAVES - 1 - int'($urandom_range(0, 15)));
            end
            3: hi = (lo == '0) ? '0 : IDX_W'($urandom_range(0, int'(lo) - 1));
            default: begin
                w = $urandom_range(0, 127);
                hi = (int'(lo) + w > LEAVES - 1) ? LAST_IDX : IDX_W'(int'(lo) + w);
            end
        endcase
        send_item(op, lo, hi, val);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, single elements, empty ranges
        send_item(OP_QUERY, 10'd0, LAST_IDX, 32'd0);
        send_item(OP_ADD, 10'd0, LAST_IDX, 32'h7fffffff);
        send_item(OP_QUERY, 10'd0, LAST_IDX, 32'd0);
        send_item(OP_ADD, 10'd0, 10'd0, 32'h80000000);
        send_item(OP_ADD, LAST_IDX, LAST_IDX, 32'hffffffff);
        send_item(OP_QUERY, 10'd0, 10'd0, 32'hffffffff);
        send_item(OP_QUERY, LAST_IDX, LAST_IDX, 32'd0);
        send_item(OP_ADD, 10'd700, 10'd5, 32'h12345678);
        send_item(OP_QUERY, 10'd700, 10'd5, 32'd0);
        send_item(OP_QUERY, LAST_IDX, 10'd0, 32'd0);
        send_item(OP_ADD, 10'd511, 10'd512, 32'h00000001);
        send_item(OP_QUERY, 10'd510, 10'd513, 32'd0);
        send_item(OP_ADD, 10'd1, IDX_W'(LEAVES - 2), 32'h80000000);
        send_item(OP_QUERY, 10'd0, LAST_IDX, 32'd0);
        send_item(OP_QUERY, 10'd1, 10'd1, 32'd0);
        send_item(OP_ADD, 10'd341, 10'd682, 32'h55555555);
        send_item(OP_QUERY, 10'd340, 10'd683, 32'd0);
        send_item(OP_QUERY, 10'd0, 10'd511, 32'd0);
        send_item(OP_QUERY, 10'd512, LAST_IDX, 32'd0);
        s_tvalid <= 1'b0;

        // hold off until every query so far has answered
        wait (sb.pending_sums.size() == 0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            send_random();
        end
        s_tvalid <= 1'b0;

        wait (sb.pending_sums.size() == 0);
        repeat (300) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_sums.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
